@@ design/flmd_pkg.sv @@
// ----------------------------------------------------------------------------
// flmd_pkg: shared types and constants for the log-magnitude display block
// Beat layouts, register indexes, channel codes and the log2 lookup table.
// ----------------------------------------------------------------------------
package flmd_pkg;

    localparam int COEF_W  = 24;
    localparam int MAG_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int LOG_W   = 21;   // log2 in Q16, integer part at most 23
    localparam int SQ_W    = 47;   // (-2^23)^2 = 2^46
    localparam int RAD_W   = 48;
    localparam int REM_W   = 26;

    // square root: two root bits per stage
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = MAG_W / SQRT_STEPS;

    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;
    localparam logic [MAG_W-1:0] MAG_MAX = 24'd11863283;

    localparam logic [1:0] REG_GAIN_RED   = 2'd0;
    localparam logic [1:0] REG_GAIN_GREEN = 2'd1;
    localparam logic [1:0] REG_GAIN_BLUE  = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] real_part;
        logic signed [COEF_W-1:0] imag_part;
        logic [1:0]               channel;
        logic                     last_in;
    } coef_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [LEVEL_W-1:0] level;
        logic [1:0]         channel_out;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic [1:0] channel;
        logic       last;
    } side_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        side_t            side;
    } mag_beat_t;

    typedef struct packed {
        logic [LOG_W-1:0] log_q16;
        logic [MAG_W-1:0] magnitude;
        side_t            side;
    } log_beat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
    } gain_bank_t;

    // round(65536*log2(1+idx/16)), idx 0..16
    function automatic logic [16:0] log2_tab(input logic [4:0] idx);
        logic [16:0] val;
        case (idx)
            5'd0:    val = 17'd0;
            5'd1:    val = 17'd5732;
            5'd2:    val = 17'd11136;
            5'd3:    val = 17'd16248;
            5'd4:    val = 17'd21098;
            5'd5:    val = 17'd25711;
            5'd6:    val = 17'd30109;
            5'd7:    val = 17'd34312;
            5'd8:    val = 17'd38336;
            5'd9:    val = 17'd42196;
            5'd10:   val = 17'd45904;
            5'd11:   val = 17'd49472;
            5'd12:   val = 17'd52911;
            5'd13:   val = 17'd56229;
            5'd14:   val = 17'd59434;
            5'd15:   val = 17'd62534;
            5'd16:   val = 17'd65536;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

endpackage

@@ design/flmd_sqrt.sv @@
// ----------------------------------------------------------------------------
// flmd_sqrt: pipelined complex modulus
// Squares both parts, sums them, and takes a rounded square root two bits
// per stage with a restoring digit recurrence.
// ----------------------------------------------------------------------------
module flmd_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  flmd_pkg::coef_t     in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output flmd_pkg::mag_beat_t out_beat
);

    localparam int S          = flmd_pkg::SQRT_STAGES;
    localparam int NUM_STAGES = S + 3;   // square, sum, root stages, round

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   load;

    flmd_pkg::side_t side_reg [NUM_STAGES];

    logic signed [2*flmd_pkg::COEF_W-1:0] prod_re;
    logic signed [2*flmd_pkg::COEF_W-1:0] prod_im;
    logic [flmd_pkg::SQ_W-1:0]            sq_re_reg;
    logic [flmd_pkg::SQ_W-1:0]            sq_im_reg;

    logic [flmd_pkg::RAD_W-1:0] rad_reg  [S];
    logic [flmd_pkg::RAD_W-1:0] rad_next [S];
    logic [flmd_pkg::REM_W-1:0] rem_reg  [1:S];
    logic [flmd_pkg::REM_W-1:0] rem_next [1:S];
    logic [flmd_pkg::MAG_W-1:0] root_reg  [1:S];
    logic [flmd_pkg::MAG_W-1:0] root_next [1:S];

    logic [flmd_pkg::REM_W+1:0] rem_w;
    logic [flmd_pkg::REM_W+1:0] trial_w;
    logic [flmd_pkg::MAG_W-1:0] root_w;
    logic [flmd_pkg::RAD_W-1:0] rad_w;

    logic                       round_up;
    logic [flmd_pkg::MAG_W-1:0] mag_reg;

    // a stage takes a new beat when it is empty or its content moves on
    always_comb
    begin
        load[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign prod_re = in_beat.real_part * in_beat.real_part;
    assign prod_im = in_beat.imag_part * in_beat.imag_part;

    // root stages, each retires SQRT_STEPS bits of the root
    always_comb
    begin
        rem_w   = '0;
        trial_w = '0;
        root_w  = '0;
        rad_w   = '0;
        for (int k = 1; k <= S; k++)
        begin
            rad_w = rad_reg[k-1];
            if (k == 1)
            begin
                rem_w  = '0;
                root_w = '0;
            end
            else
            begin
                rem_w  = {2'b00, rem_reg[k-1]};
                root_w = root_reg[k-1];
            end
            for (int j = 0; j < flmd_pkg::SQRT_STEPS; j++)
            begin
                rem_w   = {rem_w[flmd_pkg::REM_W-1:0], rad_w[flmd_pkg::RAD_W-1 -: 2]};
                rad_w   = {rad_w[flmd_pkg::RAD_W-3:0], 2'b00};
                trial_w = {2'b00, root_w, 2'b01};
                if (rem_w >= trial_w)
                begin
                    rem_w  = rem_w - trial_w;
                    root_w = {root_w[flmd_pkg::MAG_W-2:0], 1'b1};
                end
                else
                begin
                    root_w = {root_w[flmd_pkg::MAG_W-2:0], 1'b0};
                end
            end
            rem_next[k]  = rem_w[flmd_pkg::REM_W-1:0];
            root_next[k] = root_w;
            if (k < S)
            begin
                rad_next[k] = rad_w;
            end
        end
        rad_next[0] = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    end

    // round half up: bump when the remainder exceeds the root
    assign round_up = rem_reg[S] > {{(flmd_pkg::REM_W - flmd_pkg::MAG_W){1'b0}}, root_reg[S]};

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sq_re_reg           <= prod_re[flmd_pkg::SQ_W-1:0];
            sq_im_reg           <= prod_im[flmd_pkg::SQ_W-1:0];
            side_reg[0].channel <= in_beat.channel;
            side_reg[0].last    <= in_beat.last_in;
        end
        if (load[1])
        begin
            rad_reg[0] <= rad_next[0];
        end
        for (int k = 1; k <= S; k++)
        begin
            if (load[k+1])
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                if (k < S)
                begin
                    rad_reg[k] <= rad_next[k];
                end
            end
        end
        if (load[S+2])
        begin
            mag_reg <= root_reg[S] + {{(flmd_pkg::MAG_W-1){1'b0}}, round_up};
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid          = vld_reg[NUM_STAGES-1];
    assign out_beat.magnitude = mag_reg;
    assign out_beat.side      = side_reg[NUM_STAGES-1];

endmodule

@@ design/flmd_log.sv @@
// ----------------------------------------------------------------------------
// flmd_log: pipelined log2(1+magnitude) in Q16
// Leading-one search, normalize, table lookup and linear interpolation.
// ----------------------------------------------------------------------------
module flmd_log (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  flmd_pkg::mag_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output flmd_pkg::log_beat_t out_beat
);

    localparam int NUM_STAGES = 5;
    localparam int MW         = flmd_pkg::MAG_W;
    localparam int EXP_W      = $clog2(MW);
    localparam int FRAC_W     = MW - 1;
    localparam int KEY_W      = 4;
    localparam int TW         = FRAC_W - KEY_W;
    localparam int DIFF_W     = 13;
    localparam int PROD_W     = DIFF_W + TW;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   load;

    flmd_pkg::side_t side_reg [NUM_STAGES];
    logic [MW-1:0]   mag_reg  [NUM_STAGES];

    logic [MW-1:0]     x0_reg;
    logic [MW-1:0]     x1_reg;
    logic [EXP_W-1:0]  e1_reg;
    logic [EXP_W-1:0]  e2_reg;
    logic [EXP_W-1:0]  e3_reg;
    logic [15:0]       lo2_reg;
    logic [15:0]       lo3_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [TW-1:0]     t_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [flmd_pkg::LOG_W-1:0] log_reg;

    logic [EXP_W-1:0] lead_w;
    logic [MW-1:0]    norm_w;
    logic [KEY_W-1:0] key_w;
    logic [16:0]      tab_lo;
    logic [16:0]      tab_hi;
    logic [16:0]      tab_diff;

    always_comb
    begin
        load[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    // leading one of x, x is never zero
    always_comb
    begin
        lead_w = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (x0_reg[i])
            begin
                lead_w = EXP_W'(i);
            end
        end
    end

    assign norm_w   = x1_reg << (EXP_W'(MW - 1) - e1_reg);
    assign key_w    = norm_w[FRAC_W-1 -: KEY_W];
    assign tab_lo   = flmd_pkg::log2_tab({1'b0, key_w});
    assign tab_hi   = flmd_pkg::log2_tab({1'b0, key_w} + 5'd1);
    assign tab_diff = tab_hi - tab_lo;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            x0_reg      <= in_beat.magnitude + {{(MW-1){1'b0}}, 1'b1};
            mag_reg[0]  <= in_beat.magnitude;
            side_reg[0] <= in_beat.side;
        end
        if (load[1])
        begin
            x1_reg <= x0_reg;
            e1_reg <= lead_w;
        end
        if (load[2])
        begin
            e2_reg   <= e1_reg;
            lo2_reg  <= tab_lo[15:0];
            diff_reg <= tab_diff[DIFF_W-1:0];
            t_reg    <= norm_w[TW-1:0];
        end
        if (load[3])
        begin
            e3_reg   <= e2_reg;
            lo3_reg  <= lo2_reg;
            prod_reg <= diff_reg * t_reg;
        end
        if (load[4])
        begin
            log_reg <= {e3_reg, 16'd0}
                     + {{(flmd_pkg::LOG_W-16){1'b0}}, lo3_reg}
                     + {{(flmd_pkg::LOG_W-DIFF_W){1'b0}}, prod_reg[PROD_W-1:TW]};
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                mag_reg[i]  <= mag_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid          = vld_reg[NUM_STAGES-1];
    assign out_beat.log_q16   = log_reg;
    assign out_beat.magnitude = mag_reg[NUM_STAGES-1];
    assign out_beat.side      = side_reg[NUM_STAGES-1];

endmodule

@@ design/flmd_scale.sv @@
// ----------------------------------------------------------------------------
// flmd_scale: per-channel gain and ln(2) scaling
// level = round(gain * log2 * ln2 / 2^48), product split over two stages.
// ----------------------------------------------------------------------------
module flmd_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  flmd_pkg::gain_bank_t gains,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  flmd_pkg::log_beat_t  in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output flmd_pkg::result_t    out_beat
);

    localparam int NUM_STAGES = 3;
    localparam int GW         = flmd_pkg::GAIN_W;
    localparam int A_W        = GW + flmd_pkg::LOG_W;
    localparam int AH_W       = A_W - 24;
    localparam int PH_W       = AH_W + 16;
    localparam int PL_W       = 24 + 16;
    localparam int P_W        = 61;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   load;

    flmd_pkg::side_t            side_reg [NUM_STAGES];
    logic [flmd_pkg::MAG_W-1:0] mag_reg  [NUM_STAGES];

    logic [GW-1:0]   gain_sel;
    logic [A_W-1:0]  a_reg;
    logic [PH_W-1:0] ph_reg;
    logic [PL_W-1:0] pl_reg;
    logic [P_W-1:0]  p_sum;
    logic [flmd_pkg::LEVEL_W-1:0] level_reg;

    always_comb
    begin
        load[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        case (in_beat.side.channel)
            flmd_pkg::CH_RED:   gain_sel = gains.red;
            flmd_pkg::CH_GREEN: gain_sel = gains.green;
            flmd_pkg::CH_BLUE:  gain_sel = gains.blue;
            default:            gain_sel = '0;
        endcase
    end

    // P < 2^61, so the rounded level fits in 13 bits and never saturates
    assign p_sum = {ph_reg, 24'd0}
                 + {{(P_W-PL_W){1'b0}}, pl_reg}
                 + (P_W'(1) << 47);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a_reg       <= gain_sel * in_beat.log_q16;
            mag_reg[0]  <= in_beat.magnitude;
            side_reg[0] <= in_beat.side;
        end
        if (load[1])
        begin
            ph_reg <= a_reg[A_W-1:24] * flmd_pkg::LN2_Q16;
            pl_reg <= a_reg[23:0] * flmd_pkg::LN2_Q16;
        end
        if (load[2])
        begin
            level_reg <= {{(flmd_pkg::LEVEL_W-(P_W-48)){1'b0}}, p_sum[P_W-1:48]};
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                mag_reg[i]  <= mag_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid            = vld_reg[NUM_STAGES-1];
    assign out_beat.magnitude   = mag_reg[NUM_STAGES-1];
    assign out_beat.level       = level_reg;
    assign out_beat.channel_out = side_reg[NUM_STAGES-1].channel;
    assign out_beat.last_out    = side_reg[NUM_STAGES-1].last;

endmodule

@@ design/fft_log_magnitude_display.sv @@
// ----------------------------------------------------------------------------
// fft_log_magnitude_display: log-magnitude display level of FFT coefficients
// Rounded modulus, log2 by table interpolation and per-channel gain scaling.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                beat
//  coef     in         coef_valid / coef_stall  flmd_pkg::coef_t
//  pix      out        pix_valid / pix_stall    flmd_pkg::result_t
//  cfg      in         cfg_we                   cfg_index, cfg_data (gains)
//
//  one beat per cycle sustained while pix_stall is low; the square root
//  takes 12 stages at two root bits each
//  reset clears all stage valid bits and sets every gain to 1.0
//  a stall freezes only full stages, so empty stages keep filling and the
//  block keeps taking beats until the pipe is full
// ----------------------------------------------------------------------------
module fft_log_magnitude_display (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          coef_valid,
    output logic                          coef_stall,
    input  flmd_pkg::coef_t               coef_data,
    output logic                          pix_valid,
    input  logic                          pix_stall,
    output flmd_pkg::result_t             pix_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [flmd_pkg::GAIN_W-1:0]   cfg_data
);

    flmd_pkg::gain_bank_t gain_reg;

    logic                sqrt_ready;
    logic                mag_valid;
    logic                mag_ready;
    flmd_pkg::mag_beat_t mag_beat;
    logic                log_valid;
    logic                log_ready;
    flmd_pkg::log_beat_t log_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.red   <= flmd_pkg::GAIN_RESET;
            gain_reg.green <= flmd_pkg::GAIN_RESET;
            gain_reg.blue  <= flmd_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                flmd_pkg::REG_GAIN_RED:   gain_reg.red   <= cfg_data;
                flmd_pkg::REG_GAIN_GREEN: gain_reg.green <= cfg_data;
                flmd_pkg::REG_GAIN_BLUE:  gain_reg.blue  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    flmd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_ready  (sqrt_ready),
        .in_beat   (coef_data),
        .out_valid (mag_valid),
        .out_ready (mag_ready),
        .out_beat  (mag_beat)
    );

    flmd_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mag_valid),
        .in_ready  (mag_ready),
        .in_beat   (mag_beat),
        .out_valid (log_valid),
        .out_ready (log_ready),
        .out_beat  (log_beat)
    );

    flmd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gain_reg),
        .in_valid  (log_valid),
        .in_ready  (log_ready),
        .in_beat   (log_beat),
        .out_valid (pix_valid),
        .out_ready (!pix_stall),
        .out_beat  (pix_data)
    );

    assign coef_stall = !sqrt_ready;

endmodule

@@ design/flmd_checker.sv @@
// ----------------------------------------------------------------------------
// flmd_checker: port-level checks for the log-magnitude display block
// Output hold under stall and value relations of the result beat.
// ----------------------------------------------------------------------------
module flmd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              coef_stall,
    input logic              pix_valid,
    input logic              pix_stall,
    input flmd_pkg::result_t pix_data
);

    // a stalled result beat stays put
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_data))
        else $error("pix beat changed while stalled");

    // input stalls only when the pipe is full behind a stalled result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        coef_stall |-> pix_valid && pix_stall)
        else $error("coef stall without a stalled result beat");

    // channel code with no gain gives a zero level
    a_none_level: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.channel_out == flmd_pkg::CH_NONE |-> pix_data.level == '0)
        else $error("nonzero level on unused channel");

    // ln(1) is zero whatever the gain
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.magnitude == '0 |-> pix_data.level == '0)
        else $error("nonzero level for zero magnitude");

    // modulus of two 24-bit parts is bounded
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pix_data.magnitude <= flmd_pkg::MAG_MAX)
        else $error("magnitude out of range");

endmodule

bind fft_log_magnitude_display flmd_checker u_flmd_checker (.*);
